/* hdl/assert_macros.svh */
// Assertion shorthands for the colormap checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/scm_pkg.sv */
// Shared types, constants and helpers of the scalar-to-RGB colormap.
// No dependencies.
`default_nettype none
package scm_pkg;

	localparam int FRAC_BITS = 15;
	localparam int CH_W      = 16;
	localparam int Q_BITS    = 17;   // quotient bits kept by the divider
	localparam int NUM_W     = 48;   // |sample-offset| << FRAC_BITS
	localparam int DEN_W     = 32;   // |span|
	localparam int P_W       = 15;   // |s-0.5| and its powers

	localparam logic [CH_W-1:0] FX_ONE  = 16'd32768;
	localparam logic [CH_W-1:0] FX_HALF = 16'd16384;

	// register indexes
	localparam logic [2:0] REG_NORM_MODE  = 3'd0;
	localparam logic [2:0] REG_OFFSET     = 3'd1;
	localparam logic [2:0] REG_SPAN       = 3'd2;
	localparam logic [2:0] REG_COLOR_MODE = 3'd3;
	localparam logic [2:0] REG_SMOOTHNESS = 3'd4;
	localparam logic [2:0] REG_BELOW      = 3'd5;
	localparam logic [2:0] REG_ABOVE      = 3'd6;

	typedef enum logic [1:0] {
		CM_BINARY     = 2'd0,
		CM_SMOOTH     = 2'd1,
		CM_LINEAR     = 2'd2,
		CM_LINEAR_ALT = 2'd3
	} color_mode_t;

	typedef struct packed {
		logic               norm_mode;
		logic signed [31:0] offset;
		logic signed [31:0] span;
		color_mode_t        color_mode;
		logic [3:0]         smoothness;
		logic [47:0]        below;
		logic [47:0]        above;
	} cfg_t;

	// channel 0 red (47:32), 1 green, 2 blue
	function automatic logic [CH_W-1:0] chan_of(input logic [47:0] rgb, input int idx);
		return rgb[16*(2-idx) +: 16];
	endfunction

endpackage
`default_nettype wire

/* hdl/scm_sample_if.sv */
// Input channel: one signed Q16.16 sample word per handshake.
// No dependencies.
`default_nettype none
interface scm_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

/* hdl/scm_pixel_if.sv */
// Output channel: normalized value and RGB channels, Q1.15 each.
// No dependencies.
`default_nettype none
interface scm_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] normalized;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;

	modport source (output valid, output normalized, output red, output green,
		output blue, input ready);
	modport sink   (input valid, input normalized, input red, input green,
		input blue, output ready);
endinterface
`default_nettype wire

/* hdl/scm_regs.sv */
// APB-style configuration registers of the colormap.
// Depends on scm_pkg.
`default_nettype none
module scm_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready,
	output scm_pkg::cfg_t cfg
);
	import scm_pkg::*;

	logic       wr_en;
	logic [2:0] idx;
	cfg_t       cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[5:3];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.norm_mode  <= 1'b1;
			cfg_q.offset     <= 32'sd0;
			cfg_q.span       <= 32'sd65536;
			cfg_q.color_mode <= CM_LINEAR;
			cfg_q.smoothness <= 4'd0;
			cfg_q.below      <= 48'd0;
			cfg_q.above      <= 48'hFFFF_FFFF_FFFF;
		end else if (wr_en) begin
			unique case (idx)
				REG_NORM_MODE:  cfg_q.norm_mode  <= pwdata[0];
				REG_OFFSET:     cfg_q.offset     <= pwdata[31:0];
				REG_SPAN:       cfg_q.span       <= pwdata[31:0];
				REG_COLOR_MODE: cfg_q.color_mode <= color_mode_t'(pwdata[1:0]);
				REG_SMOOTHNESS: cfg_q.smoothness <= pwdata[3:0];
				REG_BELOW:      cfg_q.below      <= pwdata[47:0];
				REG_ABOVE:      cfg_q.above      <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_NORM_MODE:  prdata = 64'(cfg_q.norm_mode);
			REG_OFFSET:     prdata = 64'(unsigned'(cfg_q.offset));
			REG_SPAN:       prdata = 64'(unsigned'(cfg_q.span));
			REG_COLOR_MODE: prdata = 64'(cfg_q.color_mode);
			REG_SMOOTHNESS: prdata = 64'(cfg_q.smoothness);
			REG_BELOW:      prdata = 64'(cfg_q.below);
			REG_ABOVE:      prdata = 64'(cfg_q.above);
			default:        prdata = 64'd0;
		endcase
	end
endmodule
`default_nettype wire

/* hdl/scm_norm.sv */
// Normalization: (sample-offset)/span as a pipelined restoring divider,
// one quotient bit per stage, then rounding, half offset and clip.
// Depends on scm_pkg.
`default_nettype none
module scm_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic signed [31:0] sample,
	input  scm_pkg::cfg_t      cfg,
	output logic               out_valid,
	output logic [15:0]        s
);
	import scm_pkg::*;

	// stage 1: difference
	logic        vld_s1;
	logic [32:0] d_s1;

	// stage 2: magnitudes and signs
	logic             vld_s2;
	logic [NUM_W-1:0] num_s2;
	logic [DEN_W-1:0] den_s2;
	logic             neg_s2, zero_s2, pos_s2;

	// divider chain: entry 0 is stage 3, entry i is stage 3+i
	logic             vld_s3  [0:Q_BITS];
	logic [NUM_W-1:0] rem_s3  [0:Q_BITS];
	logic [Q_BITS-1:0] quo_s3 [0:Q_BITS];
	logic [DEN_W-1:0] den_s3  [0:Q_BITS];
	logic             neg_s3  [0:Q_BITS];
	logic             zero_s3 [0:Q_BITS];
	logic             pos_s3  [0:Q_BITS];
	logic             ovf_s3  [0:Q_BITS];

	// final stage
	logic        vld_s21;
	logic [15:0] s_s21;

	logic             d_neg;
	logic [32:0]      d_mag;
	logic [DEN_W-1:0] span_mag;

	assign d_neg    = d_s1[32];
	assign d_mag    = d_neg ? (~d_s1 + 33'd1) : d_s1;
	assign span_mag = cfg.span[31] ? (~unsigned'(cfg.span) + 32'd1) : unsigned'(cfg.span);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3[0] <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3[0] <= vld_s2;
		end
	end

	// front stages
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1       <= {sample[31], sample} - {cfg.offset[31], cfg.offset};
			num_s2     <= {d_mag, {FRAC_BITS{1'b0}}};
			den_s2     <= span_mag;
			neg_s2     <= d_neg ^ cfg.span[31];
			zero_s2    <= (cfg.span == 32'sd0);
			pos_s2     <= !d_neg && (d_s1 != 33'd0);
			// quotient would not fit Q_BITS: saturate later
			ovf_s3[0]  <= {1'b0, num_s2[NUM_W-1:Q_BITS]} >= den_s2;
			rem_s3[0]  <= num_s2;
			quo_s3[0]  <= '0;
			den_s3[0]  <= den_s2;
			neg_s3[0]  <= neg_s2;
			zero_s3[0] <= zero_s2;
			pos_s3[0]  <= pos_s2;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar g = 0; g < Q_BITS; g++) begin : g_step
		localparam int SH = Q_BITS - 1 - g;
		logic [NUM_W:0]    trial;
		logic              ge;
		logic [Q_BITS-1:0] quo_nx;

		assign trial = (NUM_W+1)'(den_s3[g]) << SH;
		assign ge    = {1'b0, rem_s3[g]} >= trial;

		always_comb begin
			quo_nx     = quo_s3[g];
			quo_nx[SH] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[g+1] <= 1'b0;
			end else if (adv) begin
				vld_s3[g+1] <= vld_s3[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s3[g+1]  <= ge ? (rem_s3[g] - trial[NUM_W-1:0]) : rem_s3[g];
				quo_s3[g+1]  <= quo_nx;
				den_s3[g+1]  <= den_s3[g];
				neg_s3[g+1]  <= neg_s3[g];
				zero_s3[g+1] <= zero_s3[g];
				pos_s3[g+1]  <= pos_s3[g];
				ovf_s3[g+1]  <= ovf_s3[g];
			end
		end
	end

	// floor rounding, half offset, clip
	logic [Q_BITS:0]    mag;
	logic signed [19:0] val;
	logic [15:0]        s_nx;

	always_comb begin
		mag = {1'b0, quo_s3[Q_BITS]}
			+ (Q_BITS+1)'(neg_s3[Q_BITS] && (rem_s3[Q_BITS] != '0));
		val = neg_s3[Q_BITS] ? -signed'(20'(mag)) : signed'(20'(mag));
		if (!cfg.norm_mode) begin
			val = val + signed'(20'(FX_HALF));
		end
		priority if (zero_s3[Q_BITS]) begin
			s_nx = pos_s3[Q_BITS] ? FX_ONE : 16'd0;
		end else if (ovf_s3[Q_BITS]) begin
			s_nx = neg_s3[Q_BITS] ? 16'd0 : FX_ONE;
		end else if (val[19]) begin
			s_nx = 16'd0;
		end else if (val > signed'(20'(FX_ONE))) begin
			s_nx = FX_ONE;
		end else begin
			s_nx = val[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s21 <= 1'b0;
		end else if (adv) begin
			vld_s21 <= vld_s3[Q_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s21 <= s_nx;
		end
	end

	assign out_valid = vld_s21;
	assign s         = s_s21;
endmodule
`default_nettype wire

/* hdl/scm_pow.sv */
// Power chain for the smooth rule: p = |s-0.5|^(k+1), one rounded
// multiply per stage, k saturated to MAX_SMOOTHNESS.
// Depends on scm_pkg.
`default_nettype none
module scm_pow #(
	parameter int MAX_SMOOTHNESS = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  logic [15:0]      s,
	input  scm_pkg::cfg_t    cfg,
	output logic             out_valid,
	output logic [15:0]      s_out,
	output logic             low,
	output logic [scm_pkg::P_W-1:0] p
);
	import scm_pkg::*;

	// entry 0 is the distance stage, entry j+1 holds the power after j+1 steps
	logic           vld_s1 [0:MAX_SMOOTHNESS];
	logic [15:0]    s_s1   [0:MAX_SMOOTHNESS];
	logic           low_s1 [0:MAX_SMOOTHNESS];
	logic [P_W-1:0] d_s1   [0:MAX_SMOOTHNESS];
	logic [P_W-1:0] p_s1   [0:MAX_SMOOTHNESS];
	logic [3:0]     k_s1   [0:MAX_SMOOTHNESS];

	logic           is_low;
	logic [P_W-1:0] gap;
	logic [3:0]     k_eff;

	assign is_low = s < FX_HALF;
	assign gap    = is_low ? P_W'(FX_HALF - s) : P_W'(s - FX_HALF);
	assign k_eff  = (32'(cfg.smoothness) > MAX_SMOOTHNESS) ? 4'(MAX_SMOOTHNESS)
		: cfg.smoothness;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1[0] <= 1'b0;
		end else if (adv) begin
			vld_s1[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1[0]   <= s;
			low_s1[0] <= is_low;
			d_s1[0]   <= gap;
			p_s1[0]   <= gap;
			k_s1[0]   <= k_eff;
		end
	end

	for (genvar j = 0; j < MAX_SMOOTHNESS; j++) begin : g_mul
		logic [2*P_W:0] prod;
		logic [2*P_W:0] rnd;

		assign prod = (2*P_W+1)'(p_s1[j]) * (2*P_W+1)'(d_s1[j]);
		assign rnd  = (prod + (2*P_W+1)'(FX_HALF)) >> FRAC_BITS;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s1[j+1] <= vld_s1[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				s_s1[j+1]   <= s_s1[j];
				low_s1[j+1] <= low_s1[j];
				d_s1[j+1]   <= d_s1[j];
				k_s1[j+1]   <= k_s1[j];
				p_s1[j+1]   <= (32'(k_s1[j]) > j) ? rnd[P_W-1:0] : p_s1[j];
			end
		end
	end

	assign out_valid = vld_s1[MAX_SMOOTHNESS];
	assign s_out     = s_s1[MAX_SMOOTHNESS];
	assign low       = low_s1[MAX_SMOOTHNESS];
	assign p         = p_s1[MAX_SMOOTHNESS];
endmodule
`default_nettype wire

/* hdl/scm_blend.sv */
// Color rules per channel lane: products in the first stage, rounding,
// sum and saturation into the output register in the second.
// Depends on scm_pkg.
`default_nettype none
module scm_blend (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  logic [15:0]      s,
	input  logic             low,
	input  logic [scm_pkg::P_W-1:0] p,
	input  scm_pkg::cfg_t    cfg,
	output logic             out_valid,
	output logic [15:0]      normalized,
	output logic [15:0]      red,
	output logic [15:0]      green,
	output logic [15:0]      blue
);
	import scm_pkg::*;

	logic           vld_s1, vld_s2;
	logic [15:0]    s_s1, s_s2;
	logic [P_W-1:0] p_s1;
	color_mode_t    mode_s1;
	logic [32:0]    m1_s1 [0:2];
	logic [32:0]    m2_s1 [0:2];
	logic [15:0]    ch_s2 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1    <= s;
			p_s1    <= p;
			mode_s1 <= cfg.color_mode;
			s_s2    <= s_s1;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic [15:0] bc, ac, pick;
		logic [32:0] m1_nx, m2_nx;
		logic [33:0] acc;
		logic [19:0] v;

		assign bc   = chan_of(cfg.below, c);
		assign ac   = chan_of(cfg.above, c);
		assign pick = low ? bc : ac;

		// stage 1: products
		always_comb begin
			unique case (cfg.color_mode)
				CM_BINARY: begin
					m1_nx = 33'(pick);
					m2_nx = '0;
				end
				CM_SMOOTH: begin
					m1_nx = 33'(p) * 33'(pick);
					m2_nx = '0;
				end
				CM_LINEAR, CM_LINEAR_ALT: begin
					m1_nx = 33'(17'(FX_ONE) - 17'(s)) * 33'(bc);
					m2_nx = 33'(s) * 33'(ac);
				end
			endcase
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				m1_s1[c] <= m1_nx;
				m2_s1[c] <= m2_nx;
			end
		end

		// stage 2: round, sum, saturate at 1.0
		always_comb begin
			acc = 34'(m1_s1[c]) + 34'(m2_s1[c]) + 34'(FX_HALF);
			unique case (mode_s1)
				CM_BINARY: v = m1_s1[c][19:0];
				CM_SMOOTH: v = 20'(acc >> FRAC_BITS) + 20'(FX_HALF) - 20'(p_s1);
				CM_LINEAR, CM_LINEAR_ALT: v = 20'(acc >> FRAC_BITS);
			endcase
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ch_s2[c] <= (v > 20'(FX_ONE)) ? FX_ONE : v[15:0];
			end
		end
	end

	assign out_valid  = vld_s2;
	assign normalized = s_s2;
	assign red        = ch_s2[0];
	assign green      = ch_s2[1];
	assign blue       = ch_s2[2];
endmodule
`default_nettype wire

/* hdl/scalar_to_rgb_colormap_top.sv */
// Top level of the scalar-to-RGB colormap.
// Depends on scm_pkg, scm_sample_if, scm_pixel_if, scm_regs, scm_norm, scm_pow, scm_blend.
//
// Takes one Q16.16 sample word per clock and returns one word per sample in
// order: the clipped normalized value and three saturated Q1.15 channels.
// The pipeline has three front stages, a 17-stage restoring divider for
// (sample-offset)/span, one clip stage, one plus MAX_SMOOTHNESS stages of
// the smooth-rule power chain, and two color stages ending in the output
// register. The whole pipeline advances whenever the output register is
// empty or taken, so a new sample is taken every cycle while the output
// flows; a word held at the output stalls the whole pipeline and the input
// with it. Write configuration only while idle.
`default_nettype none
module scalar_to_rgb_colormap_top #(
	parameter int MAX_SMOOTHNESS = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready,
	scm_sample_if.sink    samples,
	scm_pixel_if.source   pixels
);
	import scm_pkg::*;

	cfg_t           cfg;
	logic           adv;
	logic           n_valid, w_valid, w_low;
	logic [15:0]    n_s, w_s;
	logic [P_W-1:0] w_p;

	// global advance: output register empty or being taken
	assign adv           = !pixels.valid || pixels.ready;
	assign samples.ready = adv;

	scm_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .cfg(cfg)
	);

	scm_norm u_norm (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(samples.valid),
		.sample(samples.sample), .cfg(cfg), .out_valid(n_valid), .s(n_s)
	);

	scm_pow #(.MAX_SMOOTHNESS(MAX_SMOOTHNESS)) u_pow (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(n_valid), .s(n_s),
		.cfg(cfg), .out_valid(w_valid), .s_out(w_s), .low(w_low), .p(w_p)
	);

	scm_blend u_blend (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(w_valid), .s(w_s),
		.low(w_low), .p(w_p), .cfg(cfg), .out_valid(pixels.valid),
		.normalized(pixels.normalized), .red(pixels.red),
		.green(pixels.green), .blue(pixels.blue)
	);
endmodule
`default_nettype wire

/* hdl/scm_checker.sv */
// Port-level checks of the colormap, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module scm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] normalized,
	input logic [15:0] red,
	input logic [15:0] green,
	input logic [15:0] blue
);
	logic [63:0] word;
	logic        in_range;

	assign word     = {normalized, red, green, blue};
	assign in_range = (normalized <= 16'd32768) && (red <= 16'd32768)
		&& (green <= 16'd32768) && (blue <= 16'd32768);

	// an empty output register never blocks the input
	`CHK_IMPL(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
	// input is never held off while the output word is taken
	`CHK_IMPL(a_ready_on_take, out_ready, in_ready, "input stalled while output taken")
	// a stalled word stays put
	`CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(word), "stalled word changed")
	// every field saturates at 1.0
	`CHK_IMPL(a_range, out_valid, in_range, "field above 1.0")
endmodule

bind scalar_to_rgb_colormap_top scm_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_ready(samples.ready),
	.out_valid(pixels.valid), .out_ready(pixels.ready),
	.normalized(pixels.normalized), .red(pixels.red),
	.green(pixels.green), .blue(pixels.blue)
);
`default_nettype wire
